// File: hw/rtl/psc_pkg.sv
package psc_pkg;

	// operation codes of an input transaction
	typedef enum logic [1:0] {
		OP_LOAD_CUR = 2'd0,
		OP_LOAD_TGT = 2'd1,
		OP_STEP     = 2'd2,
		OP_READ     = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] pixel_index;
		logic [31:0] pixel_value;
		logic [7:0]  offset_x;
		logic [7:0]  offset_y;
	} item_t;

	typedef struct packed {
		logic [31:0] read_pixel;
		logic [2:0]  chosen_neighbour;
		logic [17:0] best_gain;
		logic [15:0] scan_position;
	} result_t;

	// neighbour slots: centre, then (+dx,+dy), (-dx,-dy), (-dx,+dy), (+dx,-dy)
	localparam logic [2:0] NB_CENTER = 3'd0;
	localparam logic [2:0] NB_PP     = 3'd1;
	localparam logic [2:0] NB_MM     = 3'd2;
	localparam logic [2:0] NB_MP     = 3'd3;
	localparam logic [2:0] NB_PM     = 3'd4;

	localparam logic [8:0]  DIM_MAX  = 9'd256;
	localparam logic [17:0] GAIN_MAX = 18'h3FFFF;

	// divider operand selection
	typedef enum logic [1:0] {
		DIV_SCAN = 2'd0,
		DIV_COL  = 2'd1,
		DIV_ADDR = 2'd2
	} div_sel_t;

	// distance phase: which pair is measured and how it enters the gain
	typedef enum logic [1:0] {
		PH_BASE  = 2'd0,
		PH_SELF  = 2'd1,
		PH_CUR_C = 2'd2,
		PH_TGT_C = 2'd3
	} dist_ph_t;

	typedef struct packed {
		logic      take;
		logic      clr;
		logic      div_go;
		div_sel_t  div_sel;
		logic      addr_calc;
		logic      rd_go;
		logic      rd_idx;
		logic      cap;
		logic      dist_go;
		dist_ph_t  ph;
		logic      judge;
		logic      wr_load;
		logic      wr_c;
		logic      wr_a;
		logic      out_load;
		logic [2:0] sel;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic dist_done;
		logic swap;
		logic out_free;
	} sts_t;

endpackage

// File: hw/rtl/psc_ram.sv
module psc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/psc_div.sv
module psc_div #(
	parameter int DW = 18,
	parameter int VW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quo,
	output logic [VW-1:0] rem
);

	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] dvd_q;
	logic [VW-1:0] dsr_q;
	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [VW:0]   trial;
	logic          ge;

	assign trial = {rem_q, dvd_q[DW-1]};
	assign ge    = trial >= {1'b0, dsr_q};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			rem_q <= ge ? VW'(trial - {1'b0, dsr_q}) : VW'(trial);
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// File: hw/rtl/psc_dist.sv
module psc_dist (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] p,
	input  logic [31:0] q,
	output logic        done,
	output logic [16:0] dist_val
);

	localparam int PRE   = 4;
	localparam int STEPS = 17;
	localparam int LAST  = PRE + STEPS - 1;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;

	logic signed [8:0]  dr_q, dg_q, db_q;
	logic signed [17:0] dy_q, cbi_q, cri_q;
	logic signed [25:0] cb_q, cr_q;
	logic signed [35:0] dy2_q;
	logic signed [51:0] cb2_q, cr2_q;
	logic        [48:0] csum;
	logic        [33:0] rad_n;

	logic [33:0] rad_q;
	logic [17:0] sr_q;
	logic [16:0] root_q;
	logic [19:0] sp;
	logic [19:0] strial;
	logic        sge;

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(LAST)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// channel differences
	always_ff @(posedge clk) begin
		if (start) begin
			dr_q <= $signed({1'b0, p[7:0]}) - $signed({1'b0, q[7:0]});
			dg_q <= $signed({1'b0, p[15:8]}) - $signed({1'b0, q[15:8]});
			db_q <= $signed({1'b0, p[23:16]}) - $signed({1'b0, q[23:16]});
		end
	end

	// luma and chroma terms, then the squares
	always_ff @(posedge clk) begin
		dy_q  <= 18'sd77 * dr_q + 18'sd150 * dg_q + 18'sd29 * db_q;
		cbi_q <= 18'sd256 * db_q - (18'sd77 * dr_q + 18'sd150 * dg_q + 18'sd29 * db_q);
		cri_q <= 18'sd256 * dr_q - (18'sd77 * dr_q + 18'sd150 * dg_q + 18'sd29 * db_q);
		cb_q  <= 26'sd144 * cbi_q;
		cr_q  <= 26'sd183 * cri_q;
		dy2_q <= dy_q * dy_q;
		cb2_q <= cb_q * cb_q;
		cr2_q <= cr_q * cr_q;
	end

	assign csum  = {1'b0, cb2_q[47:0]} + {1'b0, cr2_q[47:0]};
	assign rad_n = {2'b00, dy2_q[31:0]} + {2'b00, csum[48:17]};

	assign sp     = {sr_q, rad_q[33:32]};
	assign strial = {1'b0, root_q, 2'b01};
	assign sge    = sp >= strial;

	// square root, one root bit a cycle
	always_ff @(posedge clk) begin
		if (busy_q && cnt_q == 5'(PRE - 1)) begin
			rad_q  <= rad_n;
			sr_q   <= '0;
			root_q <= '0;
		end else if (busy_q && cnt_q >= 5'(PRE)) begin
			rad_q  <= {rad_q[31:0], 2'b00};
			sr_q   <= sge ? 18'(sp - strial) : 18'(sp);
			root_q <= {root_q[15:0], sge};
		end
	end

	assign done     = done_q;
	assign dist_val = root_q;

endmodule

// File: hw/rtl/psc_datapath.sv
module psc_datapath #(
	parameter int MAX_PIXELS = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  psc_pkg::cmd_t    cmd,
	output psc_pkg::sts_t    sts,
	input  psc_pkg::item_t   item,
	input  logic [8:0]       width_cfg,
	input  logic [8:0]       height_cfg,
	output logic             result_valid,
	input  logic             result_stall,
	output psc_pkg::result_t result
);

	import psc_pkg::*;

	localparam int AW   = $clog2(MAX_PIXELS);
	localparam int NCAP = (MAX_PIXELS > 65536) ? 65536 : MAX_PIXELS;
	localparam int DW   = 18;
	localparam int VW   = 17;

	item_t       item_q;
	logic [8:0]  w_eff, h_eff;
	logic [17:0] prod;
	logic [16:0] n;
	logic        idx_ok;

	logic [15:0] scan_q;
	logic [15:0] q1_q;
	logic [8:0]  x_q, y_q;

	logic [DW-1:0] dvd;
	logic [VW-1:0] dsr;
	logic          div_done;
	logic [DW-1:0] div_quo;
	logic [VW-1:0] div_rem;
	logic [16:0]   fix;

	logic signed [10:0] xx, yy, xs, ys, dxs, dys;
	logic signed [20:0] v_n;
	logic               neg_q;
	logic [17:0]        mag_q;
	logic [AW-1:0]      addr_q [5];

	logic          cur_we;
	logic [AW-1:0] cur_waddr;
	logic [31:0]   cur_wdata;
	logic          tgt_we;
	logic [AW-1:0] raddr;
	logic [31:0]   cur_rd, tgt_rd;

	logic [31:0] cur_c_q, tgt_c_q, cur_a_q, tgt_a_q, rpix_q, nbcur_q;

	logic [31:0] dp, dq;
	logic        dist_done;
	logic [16:0] dist_val;
	logic [16:0] base_q;
	logic signed [19:0] gain_q, best_q;
	logic [2:0]  choice_q;
	logic [17:0] gain_sat;

	logic    out_valid_q;
	result_t out_q;

	// effective image size and pixel count
	always_comb begin
		w_eff = (width_cfg == 9'd0) ? 9'd1 : ((width_cfg > DIM_MAX) ? DIM_MAX : width_cfg);
		h_eff = (height_cfg == 9'd0) ? 9'd1 : ((height_cfg > DIM_MAX) ? DIM_MAX : height_cfg);
		prod  = w_eff * h_eff;
		n     = (prod > 18'(NCAP)) ? 17'(NCAP) : 17'(prod);
	end

	assign idx_ok = {1'b0, item_q.pixel_index} < n;

	// latch the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_q <= item;
		end
	end

	// divider operands
	always_comb begin
		case (cmd.div_sel)
			DIV_SCAN: begin
				dvd = {2'b00, scan_q};
				dsr = {8'b0, h_eff};
			end
			DIV_COL: begin
				dvd = {2'b00, q1_q};
				dsr = {8'b0, w_eff};
			end
			default: begin
				dvd = mag_q;
				dsr = n;
			end
		endcase
	end

	psc_div #(.DW(DW), .VW(VW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_go),
		.dividend (dvd),
		.divisor  (dsr),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	// neighbour coordinates and linear address before the wrap
	always_comb begin
		xs  = $signed({2'b00, x_q});
		ys  = $signed({2'b00, y_q});
		dxs = $signed({3'b000, item_q.offset_x});
		dys = $signed({3'b000, item_q.offset_y});
		case (cmd.sel)
			NB_PP: begin
				xx = xs + dxs;
				yy = ys + dys;
			end
			NB_MM: begin
				xx = xs - dxs;
				yy = ys - dys;
			end
			NB_MP: begin
				xx = xs - dxs;
				yy = ys + dys;
			end
			NB_PM: begin
				xx = xs + dxs;
				yy = ys - dys;
			end
			default: begin
				xx = xs;
				yy = ys;
			end
		endcase
		v_n = yy * $signed({1'b0, w_eff}) + xx;
	end

	assign fix = (neg_q && div_rem != '0) ? n - div_rem : div_rem;

	// scan geometry and wrapped addresses
	always_ff @(posedge clk) begin
		if (cmd.addr_calc) begin
			neg_q <= v_n[20];
			mag_q <= v_n[20] ? 18'(-v_n) : 18'(v_n);
		end
		if (div_done) begin
			case (cmd.div_sel)
				DIV_SCAN: begin
					q1_q <= div_quo[15:0];
					y_q  <= div_rem[8:0];
				end
				DIV_COL: begin
					x_q <= div_rem[8:0];
				end
				default: begin
					addr_q[cmd.sel] <= AW'(fix);
				end
			endcase
		end
	end

	// image memories
	always_comb begin
		raddr     = cmd.rd_idx ? AW'(item_q.pixel_index) : addr_q[cmd.sel];
		cur_we    = (cmd.wr_load && item_q.op == OP_LOAD_CUR && idx_ok) || cmd.wr_c || cmd.wr_a;
		tgt_we    = cmd.wr_load && item_q.op == OP_LOAD_TGT && idx_ok;
		cur_waddr = AW'(item_q.pixel_index);
		cur_wdata = item_q.pixel_value;
		if (cmd.wr_c) begin
			cur_waddr = addr_q[NB_CENTER];
			cur_wdata = nbcur_q;
		end else if (cmd.wr_a) begin
			cur_waddr = addr_q[choice_q];
			cur_wdata = cur_c_q;
		end
	end

	psc_ram #(.WIDTH(32), .DEPTH(MAX_PIXELS)) u_cur_ram (
		.clk   (clk),
		.we    (cur_we),
		.waddr (cur_waddr),
		.wdata (cur_wdata),
		.re    (cmd.rd_go),
		.raddr (raddr),
		.rdata (cur_rd)
	);

	psc_ram #(.WIDTH(32), .DEPTH(MAX_PIXELS)) u_tgt_ram (
		.clk   (clk),
		.we    (tgt_we),
		.waddr (AW'(item_q.pixel_index)),
		.wdata (item_q.pixel_value),
		.re    (cmd.rd_go),
		.raddr (raddr),
		.rdata (tgt_rd)
	);

	// capture read data
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			if (cmd.rd_idx) begin
				rpix_q <= idx_ok ? cur_rd : 32'd0;
			end else if (cmd.sel == NB_CENTER) begin
				cur_c_q <= cur_rd;
				tgt_c_q <= tgt_rd;
			end else begin
				cur_a_q <= cur_rd;
				tgt_a_q <= tgt_rd;
			end
		end
	end

	// distance operands
	always_comb begin
		case (cmd.ph)
			PH_BASE: begin
				dp = tgt_c_q;
				dq = cur_c_q;
			end
			PH_SELF: begin
				dp = tgt_a_q;
				dq = cur_a_q;
			end
			PH_CUR_C: begin
				dp = tgt_a_q;
				dq = cur_c_q;
			end
			default: begin
				dp = tgt_c_q;
				dq = cur_a_q;
			end
		endcase
	end

	psc_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.dist_go),
		.p        (dp),
		.q        (dq),
		.done     (dist_done),
		.dist_val (dist_val)
	);

	// accumulate the gain of one neighbour
	always_ff @(posedge clk) begin
		if (dist_done) begin
			case (cmd.ph)
				PH_BASE:  base_q <= dist_val;
				PH_SELF:  gain_q <= $signed({3'b000, base_q}) + $signed({3'b000, dist_val});
				default:  gain_q <= gain_q - $signed({3'b000, dist_val});
			endcase
		end
		if (cmd.judge && gain_q > best_q) begin
			nbcur_q <= cur_a_q;
		end
	end

	// keep the best neighbour; ties keep the earlier choice
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q   <= '0;
			choice_q <= NB_CENTER;
		end else if (cmd.clr) begin
			best_q   <= '0;
			choice_q <= NB_CENTER;
		end else if (cmd.judge && gain_q > best_q) begin
			best_q   <= gain_q;
			choice_q <= cmd.sel;
		end
	end

	assign gain_sat = (best_q[19:18] != 2'b00) ? GAIN_MAX : best_q[17:0];

	// scan counter and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				if (item_q.op == OP_STEP) begin
					scan_q <= scan_q + 16'd1;
				end
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.read_pixel       <= (item_q.op == OP_READ) ? rpix_q : 32'd0;
			out_q.chosen_neighbour <= (item_q.op == OP_STEP) ? choice_q : 3'd0;
			out_q.best_gain        <= (item_q.op == OP_STEP) ? gain_sat : 18'd0;
			out_q.scan_position    <= (item_q.op == OP_STEP) ? scan_q : 16'd0;
		end
	end

	assign result_valid  = out_valid_q;
	assign result        = out_q;
	assign sts.div_done  = div_done;
	assign sts.dist_done = dist_done;
	assign sts.swap      = choice_q != NB_CENTER;
	assign sts.out_free  = !out_valid_q || !result_stall;

endmodule

// File: hw/rtl/psc_ctrl.sv
module psc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  psc_pkg::op_t  item_op,
	output logic          item_stall,
	output psc_pkg::cmd_t cmd,
	input  psc_pkg::sts_t sts
);

	import psc_pkg::*;

	typedef enum logic [18:0] {
		S_IDLE    = 19'h00001,
		S_LOAD    = 19'h00002,
		S_RDI     = 19'h00004,
		S_RDI_CAP = 19'h00008,
		S_DSCAN   = 19'h00010,
		S_WSCAN   = 19'h00020,
		S_DCOL    = 19'h00040,
		S_WCOL    = 19'h00080,
		S_ACALC   = 19'h00100,
		S_DADR    = 19'h00200,
		S_WADR    = 19'h00400,
		S_RD      = 19'h00800,
		S_CAP     = 19'h01000,
		S_DST     = 19'h02000,
		S_WDST    = 19'h04000,
		S_JUDGE   = 19'h08000,
		S_WRC     = 19'h10000,
		S_WRA     = 19'h20000,
		S_OUT     = 19'h40000
	} state_t;

	state_t   state_q, state_n;
	logic [2:0] j_q, j_n;
	dist_ph_t ph_q, ph_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q     <= NB_CENTER;
			ph_q    <= PH_BASE;
		end else begin
			state_q <= state_n;
			j_q     <= j_n;
			ph_q    <= ph_n;
		end
	end

	// sequence one transaction
	always_comb begin
		state_n     = state_q;
		j_n         = j_q;
		ph_n        = ph_q;
		cmd         = '0;
		cmd.sel     = j_q;
		cmd.ph      = ph_q;
		cmd.div_sel = DIV_ADDR;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.take = 1'b1;
					case (item_op)
						OP_LOAD_CUR: state_n = S_LOAD;
						OP_LOAD_TGT: state_n = S_LOAD;
						OP_READ:     state_n = S_RDI;
						default:     state_n = S_DSCAN;
					endcase
				end
			end
			S_LOAD: begin
				cmd.wr_load = 1'b1;
				state_n     = S_OUT;
			end
			S_RDI: begin
				cmd.rd_go  = 1'b1;
				cmd.rd_idx = 1'b1;
				state_n    = S_RDI_CAP;
			end
			S_RDI_CAP: begin
				cmd.cap    = 1'b1;
				cmd.rd_idx = 1'b1;
				state_n    = S_OUT;
			end
			S_DSCAN: begin
				cmd.clr     = 1'b1;
				cmd.div_go  = 1'b1;
				cmd.div_sel = DIV_SCAN;
				state_n     = S_WSCAN;
			end
			S_WSCAN: begin
				cmd.div_sel = DIV_SCAN;
				if (sts.div_done) begin
					state_n = S_DCOL;
				end
			end
			S_DCOL: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = DIV_COL;
				state_n     = S_WCOL;
			end
			S_WCOL: begin
				cmd.div_sel = DIV_COL;
				if (sts.div_done) begin
					j_n     = NB_CENTER;
					state_n = S_ACALC;
				end
			end
			S_ACALC: begin
				cmd.addr_calc = 1'b1;
				state_n       = S_DADR;
			end
			S_DADR: begin
				cmd.div_go = 1'b1;
				state_n    = S_WADR;
			end
			S_WADR: begin
				if (sts.div_done) begin
					if (j_q == NB_PM) begin
						j_n     = NB_CENTER;
						state_n = S_RD;
					end else begin
						j_n     = j_q + 3'd1;
						state_n = S_ACALC;
					end
				end
			end
			S_RD: begin
				cmd.rd_go = 1'b1;
				state_n   = S_CAP;
			end
			S_CAP: begin
				cmd.cap = 1'b1;
				ph_n    = (j_q == NB_CENTER) ? PH_BASE : PH_SELF;
				state_n = S_DST;
			end
			S_DST: begin
				cmd.dist_go = 1'b1;
				state_n     = S_WDST;
			end
			S_WDST: begin
				if (sts.dist_done) begin
					case (ph_q)
						PH_BASE: begin
							j_n     = NB_PP;
							state_n = S_RD;
						end
						PH_SELF: begin
							ph_n    = PH_CUR_C;
							state_n = S_DST;
						end
						PH_CUR_C: begin
							ph_n    = PH_TGT_C;
							state_n = S_DST;
						end
						default: state_n = S_JUDGE;
					endcase
				end
			end
			S_JUDGE: begin
				cmd.judge = 1'b1;
				if (j_q == NB_PM) begin
					state_n = S_WRC;
				end else begin
					j_n     = j_q + 3'd1;
					state_n = S_RD;
				end
			end
			S_WRC: begin
				if (sts.swap) begin
					cmd.wr_c = 1'b1;
					state_n  = S_WRA;
				end else begin
					state_n = S_OUT;
				end
			end
			S_WRA: begin
				cmd.wr_a = 1'b1;
				state_n  = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	assign item_stall = state_q != S_IDLE;

endmodule

// File: hw/rtl/pixel_swap_color_matcher.sv
// Channel  | Direction | Handshake                   | Payload
// item     | in        | item_valid / item_stall     | op, pixel_index, pixel_value, offsets
// result   | out       | result_valid / result_stall | read_pixel, chosen_neighbour, gain, scan
// config   | in        | APB psel/penable/pwrite     | image_width @0x0, image_height @0x4
//
// One transaction at a time. A swap step runs seven divides on the shared divider and
// thirteen distances on the shared distance unit, each distance with its 17-step square
// root; a step that swaps also writes both pixels back.
// item_stall is high from acceptance until the result enters the output register;
// a stalled result holds while the next transaction is accepted and worked on.
// Reset clears the scan counter and sets both sizes to 256; the images need loading.
module pixel_swap_color_matcher #(
	parameter int MAX_PIXELS = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  psc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output psc_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	import psc_pkg::*;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	logic [8:0] width_q, height_q;
	cmd_t       cmd;
	sts_t       sts;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_MAX;
			height_q <= DIM_MAX;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[8:0];
				REG_HEIGHT: height_q <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WIDTH:  prdata = {23'b0, width_q};
			REG_HEIGHT: prdata = {23'b0, height_q};
			default:    prdata = 32'd0;
		endcase
	end

	assign pready = 1'b1;

	psc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_op    (item.op),
		.item_stall (item_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	psc_datapath #(.MAX_PIXELS(MAX_PIXELS)) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.width_cfg    (width_q),
		.height_cfg   (height_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: bench/tb_pixel_swap_color_matcher.sv
`timescale 1ns / 100ps

module tb_pixel_swap_color_matcher;
	import psc_pkg::*;

	localparam int NPIX = 65536;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item;
	logic        result_valid;
	logic        result_stall;
	result_t     result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pixel_swap_color_matcher i_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	localparam logic [2:0] ADDR_WIDTH  = 3'd0;
	localparam logic [2:0] ADDR_HEIGHT = 3'd4;

	// shadow of the block: images, scan counter and size registers
	logic [31:0] cur_img [NPIX];
	logic [31:0] tgt_img [NPIX];
	bit          cur_set [NPIX];
	bit          tgt_set [NPIX];
	logic [15:0] scan_cnt;
	logic [8:0]  width_reg;
	logic [8:0]  height_reg;

	result_t     pending_q[$];
	int          errors;
	int          n_results;
	int          n_steps;
	int          n_swaps;
	bit          quiet;
	int          stall_left;

	typedef struct {
		bit          reconf;
		logic [31:0] w;
		logic [31:0] h;
		item_t       it;
		bit          lit;
		result_t     res;
	} row_t;

	row_t        plan[$];

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard limit on the run
	initial begin
		#20ms;
		$display("FAIL pixel_swap_color_matcher");
		$finish;
	end

	function automatic longint eff_dim(logic [8:0] v);
		if (v == 9'd0) return 1;
		if (v > DIM_MAX) return 256;
		return longint'(v);
	endfunction

	function automatic longint pix_total();
		longint n;
		n = eff_dim(width_reg) * eff_dim(height_reg);
		return (n > NPIX) ? NPIX : n;
	endfunction

	// YCbCr distance in 1/256 units, integer square root by digit recurrence
	function automatic longint color_gap(logic [31:0] p, logic [31:0] q);
		longint dr, dg, db, yy, cb, cr, s, r, bt;
		dr = longint'(p[7:0]) - longint'(q[7:0]);
		dg = longint'(p[15:8]) - longint'(q[15:8]);
		db = longint'(p[23:16]) - longint'(q[23:16]);
		yy = 77 * dr + 150 * dg + 29 * db;
		cb = 144 * (256 * db - yy);
		cr = 183 * (256 * dr - yy);
		s = yy * yy * 65536 + ((cb * cb + cr * cr) >>> 1);
		s = s >>> 16;
		r = 0;
		bt = longint'(1) << 62;
		while (bt > s) bt = bt >>> 2;
		while (bt != 0) begin
			if (s >= r + bt) begin
				s = s - (r + bt);
				r = (r >>> 1) + bt;
			end else begin
				r = r >>> 1;
			end
			bt = bt >>> 2;
		end
		return r;
	endfunction

	function automatic int wrap_idx(longint v, longint n);
		longint m;
		m = v % n;
		if (m < 0) m = m + n;
		return int'(m);
	endfunction

	// advance the shadow by one transaction and return what the block must answer
	function automatic result_t apply_item(item_t it);
		result_t r;
		longint  n, w, h, x, y, dxo, dyo, base, g, best;
		int      c, a;
		int      nb[4];
		int      sx[4];
		int      sy[4];
		logic [2:0]  pick;
		logic [31:0] t;
		r = '0;
		n = pix_total();
		sx = '{1, -1, -1, 1};
		sy = '{1, -1, 1, -1};
		case (it.op)
			OP_LOAD_CUR: begin
				if (it.pixel_index < n) begin
					cur_img[it.pixel_index] = it.pixel_value;
					cur_set[it.pixel_index] = 1'b1;
				end
			end
			OP_LOAD_TGT: begin
				if (it.pixel_index < n) begin
					tgt_img[it.pixel_index] = it.pixel_value;
					tgt_set[it.pixel_index] = 1'b1;
				end
			end
			OP_READ: begin
				if (it.pixel_index < n) r.read_pixel = cur_img[it.pixel_index];
			end
			default: begin
				w = eff_dim(width_reg);
				h = eff_dim(height_reg);
				x = (longint'(scan_cnt) / h) % w;
				y = longint'(scan_cnt) % h;
				dxo = longint'(it.offset_x);
				dyo = longint'(it.offset_y);
				c = wrap_idx(y * w + x, n);
				base = color_gap(tgt_img[c], cur_img[c]);
				best = 0;
				pick = NB_CENTER;
				for (int k = 0; k < 4; k++) begin
					a = wrap_idx((y + sy[k] * dyo) * w + (x + sx[k] * dxo), n);
					nb[k] = a;
					g = base + color_gap(tgt_img[a], cur_img[a])
						- color_gap(tgt_img[a], cur_img[c])
						- color_gap(tgt_img[c], cur_img[a]);
					if (g > best) begin
						best = g;
						pick = 3'(k + 1);
					end
				end
				if (pick != NB_CENTER) begin
					a = nb[pick - 1];
					t = cur_img[c];
					cur_img[c] = cur_img[a];
					cur_img[a] = t;
					n_swaps++;
				end
				if (best > longint'(GAIN_MAX)) best = longint'(GAIN_MAX);
				r.chosen_neighbour = pick;
				r.best_gain = 18'(best);
				r.scan_position = scan_cnt;
				scan_cnt = scan_cnt + 16'd1;
				n_steps++;
			end
		endcase
		return r;
	endfunction

	// offer one transaction, hold it until taken, queue its expected answer
	task automatic send_item(item_t it, bit lit, result_t lit_res);
		result_t r;
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!(item_valid && !item_stall));
		r = apply_item(it);
		pending_q.push_back(lit ? lit_res : r);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// load every pixel of the current image size not yet written, in both stores
	task automatic fill_images();
		item_t   it;
		longint  n;
		result_t none;
		none = '0;
		n = pix_total();
		for (int i = 0; i < n; i++) begin
			for (int s = 0; s < 2; s++) begin
				if (s == 0 ? cur_set[i] : tgt_set[i]) continue;
				it = '0;
				it.op = (s == 0) ? OP_LOAD_CUR : OP_LOAD_TGT;
				it.pixel_index = 16'(i);
				it.pixel_value = ($urandom_range(0, 2) == 0) ? 32'h00FF_FF00 * $urandom_range(0, 1)
					: $urandom;
				send_item(it, 1'b0, none);
			end
		end
	endtask

	// resize the images: idle, write both registers, load what is new
	task automatic resize(logic [31:0] w, logic [31:0] h);
		drain();
		reg_write(ADDR_WIDTH, w);
		reg_write(ADDR_HEIGHT, h);
		width_reg = w[8:0];
		height_reg = h[8:0];
		fill_images();
	endtask

	function automatic item_t rand_item();
		item_t   it;
		longint  n;
		int      sel;
		n = pix_total();
		it.pixel_value = $urandom;
		it.offset_x = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		it.offset_y = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		it.pixel_index = ($urandom_range(0, 4) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, int'(n) - 1));
		sel = $urandom_range(0, 19);
		if (sel < 10) it.op = OP_STEP;
		else if (sel < 13) it.op = OP_LOAD_CUR;
		else if (sel < 15) it.op = OP_LOAD_TGT;
		else it.op = OP_READ;
		return it;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch %0s: got %0h expected %0h at %0t", field, got, want, $realtime);
		errors++;
	endtask

	// result side back pressure in random bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 7) - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// compare each taken result with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			n_results++;
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result", 32'(result), 32'd0);
			end else begin
				want = pending_q.pop_front();
				if (result.read_pixel !== want.read_pixel)
					report_mismatch("read_pixel", result.read_pixel, want.read_pixel);
				if (result.chosen_neighbour !== want.chosen_neighbour)
					report_mismatch("chosen_neighbour", 32'(result.chosen_neighbour),
						32'(want.chosen_neighbour));
				if (result.best_gain !== want.best_gain)
					report_mismatch("best_gain", 32'(result.best_gain), 32'(want.best_gain));
				if (result.scan_position !== want.scan_position)
					report_mismatch("scan_position", 32'(result.scan_position),
						32'(want.scan_position));
			end
		end
	end

	initial begin
		result_t zero_res;
		int      w_list[6];
		int      h_list[6];
		int      per_phase;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		errors = 0;
		n_results = 0;
		n_steps = 0;
		n_swaps = 0;
		quiet = 1'b0;
		stall_left = 0;
		scan_cnt = '0;
		width_reg = DIM_MAX;
		height_reg = DIM_MAX;
		zero_res = '0;
		for (int i = 0; i < NPIX; i++) begin
			cur_img[i] = '0;
			tgt_img[i] = '0;
			cur_set[i] = 1'b0;
			tgt_set[i] = 1'b0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows: full-size image extremes first, then a 3x3 image, then a 1x256 image
		plan.push_back('{0, 0, 0, item_t'{OP_LOAD_CUR, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF},
			1, zero_res});
		plan.push_back('{0, 0, 0, item_t'{OP_LOAD_CUR, 16'h0000, 32'h0, 8'h0, 8'h0}, 1, zero_res});
		plan.push_back('{0, 0, 0, item_t'{OP_LOAD_TGT, 16'hFFFF, 32'hFFFF_FFFF, 8'h0, 8'h0},
			1, zero_res});
		plan.push_back('{0, 0, 0, item_t'{OP_READ, 16'hFFFF, 32'h0, 8'h0, 8'h0}, 1,
			result_t'{32'hFFFF_FFFF, 3'd0, 18'd0, 16'd0}});
		plan.push_back('{0, 0, 0, item_t'{OP_READ, 16'h0000, 32'hFFFF_FFFF, 8'h0, 8'h0}, 1,
			zero_res});
		plan.push_back('{0, 0, 0, item_t'{OP_LOAD_CUR, 16'h5555, 32'h1234_5678, 8'h0, 8'h0}, 1,
			zero_res});
		plan.push_back('{0, 0, 0, item_t'{OP_READ, 16'h5555, 32'h0, 8'h0, 8'h0}, 1,
			result_t'{32'h1234_5678, 3'd0, 18'd0, 16'd0}});
		plan.push_back('{1, 32'hFFFF_FE03, 32'h0000_0203, item_t'{OP_STEP, 16'h0, 32'h0,
			8'd1, 8'd1}, 0, zero_res});
		plan.push_back('{0, 0, 0, item_t'{OP_STEP, 16'h0, 32'h0, 8'hFF, 8'hFF}, 0, zero_res});
		plan.push_back('{0, 0, 0, item_t'{OP_STEP, 16'h0, 32'h0, 8'd0, 8'd0}, 1,
			result_t'{32'h0, NB_CENTER, 18'd0, 16'd2}});
		plan.push_back('{0, 0, 0, item_t'{OP_STEP, 16'h0, 32'h0, 8'd3, 8'd3}, 0, zero_res});
		plan.push_back('{0, 0, 0, item_t'{OP_READ, 16'd9, 32'h0, 8'h0, 8'h0}, 1, zero_res});
		plan.push_back('{0, 0, 0, item_t'{OP_LOAD_CUR, 16'd9, 32'hDEAD_BEEF, 8'h0, 8'h0}, 1,
			zero_res});
		plan.push_back('{0, 0, 0, item_t'{OP_STEP, 16'h0, 32'h0, 8'd1, 8'd2}, 0, zero_res});
		plan.push_back('{0, 0, 0, item_t'{OP_STEP, 16'h0, 32'h0, 8'd2, 8'd1}, 0, zero_res});
		plan.push_back('{1, 32'd0, 32'd511, item_t'{OP_STEP, 16'h0, 32'h0, 8'd1, 8'd1}, 0,
			zero_res});
		plan.push_back('{0, 0, 0, item_t'{OP_STEP, 16'h0, 32'h0, 8'd128, 8'd255}, 0, zero_res});
		foreach (plan[i]) begin
			if (plan[i].reconf) resize(plan[i].w, plan[i].h);
			send_item(plan[i].it, plan[i].lit, plan[i].res);
		end

		// hold the sender until every answer is in
		drain();

		// random part over several image sizes, width register at 0 and 511, height register at 1 and 511
		w_list = '{4, 0, 511, 1, 7, 16};
		h_list = '{4, 1, 1, 511, 5, 16};
		per_phase = 12;
		for (int p = 0; p < 6; p++) begin
			resize(32'(w_list[p]) | ($urandom & 32'hFFFF_FE00), 32'(h_list[p]));
			if (p == 5) quiet = 1'b1;
			for (int i = 0; i < per_phase; i++) send_item(rand_item(), 1'b0, zero_res);
		end

		item_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d results, %0d swap steps with %0d swaps, six image sizes",
			n_results, n_steps, n_swaps);
		$display("sizes from 1x1 to 256x1 and 1x256 with clamped size values and out-of-image indices");
		if (errors == 0) begin
			$display("PASS pixel_swap_color_matcher");
		end else begin
			$display("FAIL pixel_swap_color_matcher");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/psc_pkg.sv
hw/rtl/psc_ram.sv
hw/rtl/psc_div.sv
hw/rtl/psc_dist.sv
hw/rtl/psc_datapath.sv
hw/rtl/psc_ctrl.sv
hw/rtl/pixel_swap_color_matcher.sv
bench/tb_pixel_swap_color_matcher.sv
